### sv/fpl_pkg.sv
package fpl_pkg;

    localparam int CNT_W = 6;
    localparam logic [15:0] STEP_TICKS_RST = 16'd40;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_EOM  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        LED_OFF   = 2'd0,
        LED_ON    = 2'd1,
        LED_BLINK = 2'd2
    } t_led;

    // token parser: skip blanks, collect digits, ignore rest of token
    typedef enum logic [2:0] {
        TS_SKIP = 3'b001,
        TS_NUM  = 3'b010,
        TS_REST = 3'b100
    } t_tok_stage;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // middle stage: table read in flight plus result fields
    typedef struct packed {
        logic                   rd;
        logic                   byp;
        logic [7:0]             byp_data;
        logic                   vld;
        logic [7:0]             rom;
        logic                   dw;
        logic                   pend;
        t_led                   led;
        logic [CNT_W-1:0]       cnt;
    } t_s1;

    // power-up half-sine profile, zero past the first half period
    function automatic logic [7:0] f_reset_duty(input logic [CNT_W-1:0] idx);
        logic [7:0] v;
        case (idx)
            6'd1:    v = 8'd32;
            6'd2:    v = 8'd63;
            6'd3:    v = 8'd94;
            6'd4:    v = 8'd123;
            6'd5:    v = 8'd150;
            6'd6:    v = 8'd175;
            6'd7:    v = 8'd196;
            6'd8:    v = 8'd215;
            6'd9:    v = 8'd231;
            6'd10:   v = 8'd243;
            6'd11:   v = 8'd250;
            6'd12:   v = 8'd254;
            6'd13:   v = 8'd254;
            6'd14:   v = 8'd250;
            6'd15:   v = 8'd243;
            6'd16:   v = 8'd231;
            6'd17:   v = 8'd215;
            6'd18:   v = 8'd196;
            6'd19:   v = 8'd175;
            6'd20:   v = 8'd150;
            6'd21:   v = 8'd123;
            6'd22:   v = 8'd94;
            6'd23:   v = 8'd63;
            6'd24:   v = 8'd32;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/fpl_ram.sv
module fpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/flow_profile_loader_player.sv
// Flow profile loader and player. Each input word is a serial byte, an
// end-of-message mark or a time tick (selected by tuser); every word gives
// exactly one result word. Bytes are parsed as a comma-separated list of
// decimal duty values into the profile table; end of message starts looped
// playback from entry 0, and each entry is held for step_ticks ticks. One
// word is accepted per clock while the output is not stalled; each result
// is registered first with the parser/sequencer update and the table read,
// then in the output register. The table comes up holding the half-sine
// profile at once through per-entry valid bits, with no clearing pass after
// reset. Write step_ticks only while no word is in flight.
module flow_profile_loader_player #(
    parameter int PROFILE_LEN = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // byte_value
    input  logic [1:0]  i_s_axis_tuser,   // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // duty[7:0], led_mode[9:8], entries_loaded[15:10]
    output logic [0:0]  o_m_axis_tuser,   // duty_write
    output logic        o_m_axis_tlast    // profile_end
);

    localparam int AW = (PROFILE_LEN > 1) ? $clog2(PROFILE_LEN) : 1;
    localparam logic [fpl_pkg::CNT_W-1:0] LEN_C  = fpl_pkg::CNT_W'(PROFILE_LEN);
    localparam logic [AW-1:0]             LAST_C = AW'(PROFILE_LEN - 1);

    // parser and sequencer state
    logic [7:0]                  r_accum,    n_accum;
    logic                        r_neg,      n_neg;
    fpl_pkg::t_tok_stage         r_stage,    n_stage;
    logic                        r_present,  n_present;
    logic [fpl_pkg::CNT_W-1:0]   r_count,    n_count;
    logic                        r_playing,  n_playing;
    logic [AW-1:0]               r_idx,      n_idx;
    logic [15:0]                 r_hold,     n_hold;
    fpl_pkg::t_led               r_light,    n_light;
    logic [15:0]                 r_step;
    logic [PROFILE_LEN-1:0]      r_vld;

    // pipeline
    logic                        r_s1_valid;
    fpl_pkg::t_s1                r_s1,       n_s1;
    logic                        r_out_valid;
    logic [7:0]                  r_duty;
    logic                        r_out_dw;
    logic                        r_out_pend;
    fpl_pkg::t_led               r_out_led;
    logic [fpl_pkg::CNT_W-1:0]   r_out_cnt;

    logic                        acc;
    logic                        s1_adv;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [7:0]                  wdata;
    logic                        re;
    logic [AW-1:0]               raddr;
    logic [7:0]                  ram_q;

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        logic [7:0]                c;
        logic                      is_dig;
        logic [7:0]                dig;
        logic [fpl_pkg::CNT_W-1:0] ec;
        logic                      fin_we;
        logic [7:0]                tok_val;
        logic [15:0]               lim;
        logic [16:0]               nxt;
        logic [AW-1:0]             nidx;

        c       = i_s_axis_tdata;
        is_dig  = (c >= fpl_pkg::CH_0) && (c <= fpl_pkg::CH_9);
        dig     = {4'd0, c[3:0]};
        ec      = r_playing ? '0 : r_count;
        fin_we  = r_present && (ec < LEN_C);
        tok_val = r_neg ? (8'd0 - r_accum) : r_accum;
        lim     = (r_step == 16'd0) ? 16'd1 : r_step;
        nxt     = {1'b0, r_hold} + 17'd1;
        nidx    = (r_idx == LAST_C) ? '0 : r_idx + AW'(1);

        n_accum   = r_accum;
        n_neg     = r_neg;
        n_stage   = r_stage;
        n_present = r_present;
        n_count   = r_count;
        n_playing = r_playing;
        n_idx     = r_idx;
        n_hold    = r_hold;
        n_light   = r_light;
        we        = 1'b0;
        waddr     = ec[AW-1:0];
        wdata     = tok_val;
        re        = 1'b0;
        raddr     = '0;
        n_s1      = '0;

        if (acc) begin
            unique case (fpl_pkg::t_op'(i_s_axis_tuser))
                fpl_pkg::OP_BYTE: begin
                    n_playing = 1'b0;
                    n_count   = ec;
                    if (c == fpl_pkg::CH_CR || c == fpl_pkg::CH_LF) begin
                        // dropped
                    end else if (c == fpl_pkg::CH_COMMA) begin
                        we        = fin_we;
                        n_count   = fin_we ? ec + 6'd1 : ec;
                        n_accum   = '0;
                        n_neg     = 1'b0;
                        n_stage   = fpl_pkg::TS_SKIP;
                        n_present = 1'b0;
                    end else begin
                        n_present = 1'b1;
                        unique case (r_stage)
                            fpl_pkg::TS_SKIP: begin
                                if (c == fpl_pkg::CH_SPACE || c == fpl_pkg::CH_TAB ||
                                    c == fpl_pkg::CH_VT || c == fpl_pkg::CH_FF) begin
                                    // leading blank
                                end else if (c == fpl_pkg::CH_PLUS) begin
                                    n_stage = fpl_pkg::TS_NUM;
                                end else if (c == fpl_pkg::CH_MINUS) begin
                                    n_neg   = 1'b1;
                                    n_stage = fpl_pkg::TS_NUM;
                                end else if (is_dig) begin
                                    n_accum = dig;
                                    n_stage = fpl_pkg::TS_NUM;
                                end else begin
                                    n_stage = fpl_pkg::TS_REST;
                                end
                            end
                            fpl_pkg::TS_NUM: begin
                                if (is_dig) begin
                                    // accum * 10 + digit, mod 256
                                    n_accum = {r_accum[4:0], 3'd0} + {r_accum[6:0], 1'b0} + dig;
                                end else begin
                                    n_stage = fpl_pkg::TS_REST;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                fpl_pkg::OP_EOM: begin
                    if (r_playing) begin
                        n_count = '0;
                    end else begin
                        we        = fin_we;
                        n_count   = fin_we ? ec + 6'd1 : ec;
                        n_accum   = '0;
                        n_neg     = 1'b0;
                        n_stage   = fpl_pkg::TS_SKIP;
                        n_present = 1'b0;
                    end
                    n_light   = (n_count == LEN_C) ? fpl_pkg::LED_BLINK : fpl_pkg::LED_ON;
                    n_playing = 1'b1;
                    n_idx     = '0;
                    n_hold    = '0;
                    re        = 1'b1;
                    raddr     = '0;
                    n_s1.dw   = 1'b1;
                end
                fpl_pkg::OP_TICK: begin
                    if (r_playing) begin
                        if (nxt >= {1'b0, lim}) begin
                            n_hold    = '0;
                            n_idx     = nidx;
                            n_s1.pend = (r_idx == LAST_C);
                            re        = 1'b1;
                            raddr     = nidx;
                            n_s1.dw   = 1'b1;
                        end else begin
                            n_hold = nxt[15:0];
                        end
                    end
                end
                fpl_pkg::OP_NONE: begin
                end
                default: begin
                end
            endcase
        end

        n_s1.rd       = re;
        // same-word write and read of one entry: ram returns old data
        n_s1.byp      = we && (waddr == raddr);
        n_s1.byp_data = wdata;
        n_s1.vld      = r_vld[raddr];
        n_s1.rom      = fpl_pkg::f_reset_duty(fpl_pkg::CNT_W'(raddr));
        n_s1.led      = n_light;
        n_s1.cnt      = n_count;
    end

    fpl_ram #(
        .WIDTH (8),
        .DEPTH (PROFILE_LEN)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum   <= '0;
            r_neg     <= 1'b0;
            r_stage   <= fpl_pkg::TS_SKIP;
            r_present <= 1'b0;
            r_count   <= '0;
            r_playing <= 1'b0;
            r_idx     <= '0;
            r_hold    <= '0;
            r_light   <= fpl_pkg::LED_OFF;
            r_step    <= fpl_pkg::STEP_TICKS_RST;
            r_vld     <= '0;
        end else begin
            r_accum   <= n_accum;
            r_neg     <= n_neg;
            r_stage   <= n_stage;
            r_present <= n_present;
            r_count   <= n_count;
            r_playing <= n_playing;
            r_idx     <= n_idx;
            r_hold    <= n_hold;
            r_light   <= n_light;
            if (i_cfg_wen) begin
                r_step <= i_cfg_wdata;
            end
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_duty      <= '0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                if (r_s1.rd) begin
                    r_duty <= r_s1.byp ? r_s1.byp_data : (r_s1.vld ? ram_q : r_s1.rom);
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out_dw   <= r_s1.dw;
            r_out_pend <= r_s1.pend;
            r_out_led  <= r_s1.led;
            r_out_cnt  <= r_s1.cnt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_cnt, r_out_led, r_duty};
    assign o_m_axis_tuser  = r_out_dw;
    assign o_m_axis_tlast  = r_out_pend;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_C)
        else $error("entry count beyond table length");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_C)
        else $error("play index beyond table length");

    a_pend_dw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_pend |-> r_out_dw)
        else $error("profile end without duty write");

    a_eom_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_s_axis_tuser == fpl_pkg::OP_EOM) |=> r_s1_valid && r_s1.rd && r_s1.dw)
        else $error("end of message did not start a table read");

    a_play_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_light != fpl_pkg::LED_OFF))
        else $error("playing with status light off");
`endif

endmodule
